/* src/psslt_pkg.sv */
`timescale 1ns / 1ps
package psslt_pkg;
  localparam int TableEntries = 32;
  localparam int IdxBits = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam int CntBits = 32;
  localparam logic [CntBits-1:0] CntMax = {CntBits{1'b1}};

  localparam logic [1:0] StUpdated = 2'd0;
  localparam logic [1:0] StFull = 2'd1;
  localparam logic [1:0] StReport = 2'd2;
  localparam logic [1:0] StEmpty = 2'd3;

  localparam logic CmdUpdate = 1'b0;
  localparam logic CmdReport = 1'b1;

  localparam logic [1:0] RegMinReceived = 2'd0;
  localparam logic [1:0] RegMaxSeq = 2'd1;
  localparam logic [1:0] RegMinLast = 2'd2;

  localparam int EntryBits = 16 * 3 + CntBits * 3;

  typedef struct packed {
    logic [15:0] source;
    logic [15:0] first;
    logic [15:0] last;
    logic [CntBits-1:0] received;
    logic [CntBits-1:0] gaps;
    logic [CntBits-1:0] dups;
  } entry_t;

  typedef struct packed {
    logic cmd;
    logic [7:0] source_hi;
    logic [7:0] source_lo;
    logic [15:0] seq;
    logic [4:0] entry_index;
  } in_word_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] entry_source_hi;
    logic [7:0] entry_source_lo;
    logic [15:0] start_seq;
    logic [15:0] latest_seq;
    logic [31:0] received_count;
    logic [31:0] gap_count;
    logic [31:0] dup_count;
    logic [16:0] expected_count;
    logic [31:0] ratio_x10000;
  } out_word_t;

  typedef struct packed {
    logic start;
    logic [CntBits+13:0] dividend;
    logic [16:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [CntBits+13:0] quotient;
  } div_rsp_t;

  function automatic logic [31:0] clip32(input logic [CntBits-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return (w > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
  endfunction
endpackage

/* src/psslt_if.sv */
`timescale 1ns / 1ps
interface psslt_in_if;
  import psslt_pkg::*;
  logic valid;
  logic ready;
  in_word_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface psslt_out_if;
  import psslt_pkg::*;
  logic valid;
  logic ready;
  out_word_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

/* src/psslt_ram.sv */
`timescale 1ns / 1ps
module psslt_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* src/psslt_div.sv */
`timescale 1ns / 1ps
module psslt_div (
  input  logic clk,
  input  logic rst,
  input  psslt_pkg::div_req_t req,
  output psslt_pkg::div_rsp_t rsp
);
  import psslt_pkg::*;
  localparam int NBits = CntBits + 14;
  localparam int CBits = $clog2(NBits + 1);
  logic [NBits-1:0] quo;
  logic [17:0] rem;
  logic [16:0] dvs;
  logic [CBits-1:0] cnt;
  logic busy;
  logic finished;
  logic [17:0] trial;
  logic [17:0] shifted;

  assign shifted = {rem[16:0], quo[NBits-1]};
  assign trial = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      finished <= 1'b0;
    end else begin
      finished <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        quo <= req.dividend;
        dvs <= req.divisor;
        rem <= '0;
        cnt <= CBits'(NBits);
      end else if (busy) begin
        if (!trial[17]) begin
          rem <= trial;
          quo <= {quo[NBits-2:0], 1'b1};
        end else begin
          rem <= shifted;
          quo <= {quo[NBits-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CBits'(1)) begin
          busy <= 1'b0;
          finished <= 1'b1;
        end
      end
    end
  end
  assign rsp = '{done: finished, quotient: quo};
endmodule

/* src/per_source_sequence_loss_tracker.sv */
`timescale 1ns / 1ps
// operation: an update scans the table slots in order from 0, reading each slot and
// comparing its source, until a match or slot 31; a new source takes the first free
// slot, and a word for a new source with no free slot is dropped; updates and filled
// reports then run a serial divide for the ratio, drops and empty reports skip it
// flow: one word at a time, the next word is accepted only after the result is taken
// reset: synchronous active-high rst empties the table valid bits and loads register
// defaults; table ram contents are not cleared
module per_source_sequence_loss_tracker (
  input  logic        clk,
  input  logic        rst,
  psslt_in_if.sink    in_ch,
  psslt_out_if.source out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import psslt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN_RD, S_SCAN, S_DECIDE, S_CALC, S_WRITE, S_REP_RD, S_REP,
    S_DIV, S_OUT
  } state_t;

  state_t state;
  logic [15:0] min_received, max_seq, min_last;
  logic [TableEntries-1:0] used;
  in_word_t cur;
  logic [IdxBits:0] scan;
  logic [IdxBits-1:0] hit, freei;
  logic hit_ok, free_ok;
  entry_t ent;
  out_word_t res;
  div_req_t dreq;
  div_rsp_t drsp;
  logic div_start;

  logic ram_we;
  logic [IdxBits-1:0] ram_raddr;
  entry_t ram_rdata;

  psslt_ram #(.Width(EntryBits), .Depth(TableEntries)) u_ram (
    .clk(clk), .we(ram_we), .waddr(hit), .wdata(ent),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  psslt_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  logic [IdxBits-1:0] scan_idx;
  assign scan_idx = scan[IdxBits-1:0];
  assign ram_raddr = (state == S_IDLE) ? in_ch.data.entry_index[IdxBits-1:0]
                     : ((cur.cmd == CmdReport) ? cur.entry_index[IdxBits-1:0] : scan_idx);
  assign in_ch.ready = (state == S_IDLE);
  assign out_ch.valid = (state == S_OUT);
  assign out_ch.data = res;

  logic [15:0] nxt, skipped;
  assign nxt = ent.last + 16'd1;
  assign skipped = cur.seq - ent.last - 16'd1;
  logic [CntBits:0] gsum;
  assign gsum = {1'b0, ent.gaps} + (CntBits+1)'(skipped);
  logic [CntBits-1:0] rinc, dinc;
  assign rinc = (ent.received == CntMax) ? CntMax : ent.received + 1'b1;
  assign dinc = (ent.dups == CntMax) ? CntMax : ent.dups + 1'b1;
  logic [16:0] expct;
  assign expct = {1'b0, ent.last - ent.first} + 17'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      min_received <= 16'd10;
      max_seq <= 16'd3;
      min_last <= 16'd100;
      used <= '0;
      div_start <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          RegMinReceived: min_received <= cfg_data;
          RegMaxSeq: max_seq <= cfg_data;
          RegMinLast: min_last <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            cur <= in_ch.data;
            scan <= '0;
            hit_ok <= 1'b0;
            free_ok <= 1'b0;
            state <= (in_ch.data.cmd == CmdReport) ? S_REP_RD : S_SCAN_RD;
          end
        end
        S_SCAN_RD: state <= S_SCAN;
        S_SCAN: begin
          if (used[scan_idx] && ram_rdata.source == {cur.source_hi, cur.source_lo}) begin
            hit_ok <= 1'b1;
            hit <= scan_idx;
            ent <= ram_rdata;
            state <= S_DECIDE;
          end else begin
            if (!used[scan_idx] && !free_ok) begin
              free_ok <= 1'b1;
              freei <= scan_idx;
            end
            if (scan == (IdxBits+1)'(TableEntries - 1)) begin
              state <= S_DECIDE;
            end else begin
              scan <= scan + 1'b1;
              state <= S_SCAN_RD;
            end
          end
        end
        S_DECIDE: begin
          if (!hit_ok && !free_ok) begin
            res <= '{status: StFull, default: '0};
            state <= S_OUT;
          end else begin
            if (!hit_ok) begin
              hit <= freei;
              used[freei] <= 1'b1;
              ent.source <= {cur.source_hi, cur.source_lo};
              ent.first <= cur.seq;
              ent.last <= cur.seq;
              ent.received <= CntBits'(1);
              ent.gaps <= '0;
              ent.dups <= '0;
              state <= S_WRITE;
            end else begin
              state <= S_CALC;
            end
          end
        end
        S_CALC: begin
          if (ent.received > CntBits'(min_received) && cur.seq < max_seq
              && ent.last > min_last) begin
            ent.first <= cur.seq;
            ent.last <= cur.seq;
            ent.received <= CntBits'(1);
            ent.gaps <= '0;
            ent.dups <= '0;
          end else if (cur.seq == nxt) begin
            ent.received <= rinc;
            ent.last <= cur.seq;
          end else if (cur.seq > nxt) begin
            ent.gaps <= gsum[CntBits] ? CntMax : gsum[CntBits-1:0];
            ent.received <= rinc;
            ent.last <= cur.seq;
          end else begin
            ent.dups <= dinc;
          end
          state <= S_WRITE;
        end
        S_WRITE: begin
          res.status <= StUpdated;
          div_start <= 1'b1;
          state <= S_DIV;
        end
        S_REP_RD: state <= S_REP;
        S_REP: begin
          if (used[cur.entry_index[IdxBits-1:0]]
              && 32'(cur.entry_index) < 32'(TableEntries)) begin
            ent <= ram_rdata;
            res.status <= StReport;
            div_start <= 1'b1;
            state <= S_DIV;
          end else begin
            res <= '{status: StEmpty, default: '0};
            state <= S_OUT;
          end
        end
        S_DIV: begin
          if (drsp.done) begin
            res.entry_source_hi <= ent.source[15:8];
            res.entry_source_lo <= ent.source[7:0];
            res.start_seq <= ent.first;
            res.latest_seq <= ent.last;
            res.received_count <= clip32(ent.received);
            res.gap_count <= clip32(ent.gaps);
            res.dup_count <= clip32(ent.dups);
            res.expected_count <= expct;
            res.ratio_x10000 <= (|drsp.quotient[CntBits+13:32]) ? 32'hFFFF_FFFF
                                : drsp.quotient[31:0];
            state <= S_OUT;
          end
        end
        S_OUT: if (out_ch.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign ram_we = (state == S_WRITE);
  assign dreq = '{
    start: div_start,
    dividend: (CntBits+14)'(ent.received) * (CntBits+14)'(14'd10000),
    divisor: expct
  };

`ifndef SYNTH
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> !out_ch.valid) else $error("ready while result pending");
  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.data.status == StFull) |-> (&used))
    else $error("drop with free slot");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.ready) |=> out_ch.valid)
    else $error("result lost");
`endif
endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
module testbench;
  import psslt_pkg::*;

  localparam int WatchdogLimit = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = RegMinReceived;
  logic [15:0] cfg_data = '0;

  psslt_in_if in_ch ();
  psslt_out_if out_ch ();

  per_source_sequence_loss_tracker i_dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // tracker mirror
  logic [15:0] min_received, max_seq, min_last;
  logic used [TableEntries];
  logic [15:0] src_tab [TableEntries];
  logic [15:0] first_tab [TableEntries];
  logic [15:0] last_tab [TableEntries];
  logic [31:0] rcv_tab [TableEntries];
  logic [31:0] gap_tab [TableEntries];
  logic [31:0] dup_tab [TableEntries];

  in_word_t pending_words[$];
  out_word_t expected_words[$];
  int errors = 0;
  int accepted = 0;
  int reports = 0;
  int drops = 0;
  int restarts = 0;
  int idle_cycles = 0;
  logic [15:0] flow_ids[$];
  logic [15:0] flow_seq[$];

  function automatic logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic out_word_t entry_view(int i, logic [1:0] st);
    out_word_t o;
    logic [16:0] expct;
    logic [47:0] prod;
    logic [47:0] q;
    expct = {1'b0, 16'(last_tab[i] - first_tab[i])} + 17'd1;
    prod = 48'(rcv_tab[i]) * 48'd10000;
    q = prod / 48'(expct);
    o.status = st;
    o.entry_source_hi = src_tab[i][15:8];
    o.entry_source_lo = src_tab[i][7:0];
    o.start_seq = first_tab[i];
    o.latest_seq = last_tab[i];
    o.received_count = rcv_tab[i];
    o.gap_count = gap_tab[i];
    o.dup_count = dup_tab[i];
    o.expected_count = expct;
    o.ratio_x10000 = (q > 48'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
    return o;
  endfunction

  function automatic out_word_t track_word(in_word_t w);
    out_word_t o;
    logic [15:0] src, nxt;
    int hit, free_slot;
    bit fresh;
    o = '0;
    src = {w.source_hi, w.source_lo};
    if (w.cmd == CmdReport) begin
      if (used[w.entry_index]) o = entry_view(w.entry_index, StReport);
      else o.status = StEmpty;
      reports++;
      return o;
    end
    hit = -1;
    free_slot = -1;
    fresh = 1'b0;
    for (int i = 0; i < TableEntries; i++) begin
      if (hit < 0 && used[i] && src_tab[i] == src) hit = i;
      if (hit < 0 && !used[i] && free_slot < 0) free_slot = i;
    end
    if (hit < 0) begin
      if (free_slot < 0) begin
        o.status = StFull;
        drops++;
        return o;
      end
      hit = free_slot;
      used[hit] = 1'b1;
      src_tab[hit] = src;
      fresh = 1'b1;
    end
    nxt = last_tab[hit] + 16'd1;
    if (fresh) begin
      first_tab[hit] = w.seq;
      last_tab[hit] = w.seq;
      rcv_tab[hit] = 32'd1;
      gap_tab[hit] = '0;
      dup_tab[hit] = '0;
    end else if (rcv_tab[hit] > 32'(min_received) && w.seq < max_seq
                 && last_tab[hit] > min_last) begin
      first_tab[hit] = w.seq;
      last_tab[hit] = w.seq;
      rcv_tab[hit] = 32'd1;
      gap_tab[hit] = '0;
      dup_tab[hit] = '0;
      restarts++;
    end else if (w.seq == nxt) begin
      rcv_tab[hit] = sat_add(rcv_tab[hit], 32'd1);
      last_tab[hit] = w.seq;
    end else if (w.seq > nxt) begin
      gap_tab[hit] = sat_add(gap_tab[hit], 32'(16'(w.seq - last_tab[hit] - 16'd1)));
      rcv_tab[hit] = sat_add(rcv_tab[hit], 32'd1);
      last_tab[hit] = w.seq;
    end else begin
      dup_tab[hit] = sat_add(dup_tab[hit], 32'd1);
    end
    return entry_view(hit, StUpdated);
  endfunction

  // driver
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.data <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_words.push_back(track_word(in_ch.data));
        accepted++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_ch.valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          in_ch.data <= pending_words.pop_front();
          in_ch.valid <= 1'b1;
          send_gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60)
                      : ($urandom_range(0, 1) ? 0 : $urandom_range(0, 3));
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  int stall = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_words.size() == 0) begin
          $error("word with nothing expected");
          errors++;
        end else begin
          automatic out_word_t e = expected_words.pop_front();
          automatic out_word_t a = out_ch.data;
          if (a.status !== e.status) begin
            $error("status exp %0d got %0d", e.status, a.status); errors++;
          end
          if (a.entry_source_hi !== e.entry_source_hi) begin
            $error("entry_source_hi exp %0d got %0d", e.entry_source_hi,
                   a.entry_source_hi); errors++;
          end
          if (a.entry_source_lo !== e.entry_source_lo) begin
            $error("entry_source_lo exp %0d got %0d", e.entry_source_lo,
                   a.entry_source_lo); errors++;
          end
          if (a.start_seq !== e.start_seq) begin
            $error("start_seq exp %0d got %0d", e.start_seq, a.start_seq); errors++;
          end
          if (a.latest_seq !== e.latest_seq) begin
            $error("latest_seq exp %0d got %0d", e.latest_seq, a.latest_seq); errors++;
          end
          if (a.received_count !== e.received_count) begin
            $error("received_count exp %0d got %0d", e.received_count,
                   a.received_count); errors++;
          end
          if (a.gap_count !== e.gap_count) begin
            $error("gap_count exp %0d got %0d", e.gap_count, a.gap_count); errors++;
          end
          if (a.dup_count !== e.dup_count) begin
            $error("dup_count exp %0d got %0d", e.dup_count, a.dup_count); errors++;
          end
          if (a.expected_count !== e.expected_count) begin
            $error("expected_count exp %0d got %0d", e.expected_count,
                   a.expected_count); errors++;
          end
          if (a.ratio_x10000 !== e.ratio_x10000) begin
            $error("ratio_x10000 exp %0d got %0d", e.ratio_x10000,
                   a.ratio_x10000); errors++;
          end
        end
      end
      if (stall > 0) begin
        stall <= stall - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 7) == 0)
          stall <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 80)
                   : $urandom_range(1, 4);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
        || (pending_words.size() == 0 && expected_words.size() == 0))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic in_word_t upd(logic [15:0] src, logic [15:0] seq);
    in_word_t w;
    w = '0;
    w.cmd = CmdUpdate;
    w.source_hi = src[15:8];
    w.source_lo = src[7:0];
    w.seq = seq;
    w.entry_index = 5'($urandom);
    return w;
  endfunction

  function automatic in_word_t rpt(logic [4:0] idx);
    in_word_t w;
    w = in_word_t'(38'({$urandom, $urandom}));
    w.cmd = CmdReport;
    w.entry_index = idx;
    return w;
  endfunction

  task automatic drain();
    while (pending_words.size() > 0 || expected_words.size() > 0 || in_ch.valid)
      @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      RegMinReceived: min_received = val;
      RegMaxSeq: max_seq = val;
      RegMinLast: min_last = val;
      default: ;
    endcase
  endtask

  task automatic random_phase(int n, int nflows);
    int k;
    logic [15:0] s;
    flow_ids.delete();
    flow_seq.delete();
    for (int f = 0; f < nflows; f++) begin
      flow_ids.push_back(16'($urandom));
      flow_seq.push_back(16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 200)));
    end
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, nflows - 1);
      case ($urandom_range(0, 19))
        0, 1: pending_words.push_back(rpt(5'($urandom)));
        2: pending_words.push_back(upd(16'($urandom), 16'($urandom)));
        3: pending_words.push_back(upd(flow_ids[k], 16'($urandom_range(0, 4))));
        4, 5: pending_words.push_back(upd(flow_ids[k], flow_seq[k] - 16'($urandom_range(0, 5))));
        6, 7: begin
          s = flow_seq[k] + 16'($urandom_range(2, 40));
          flow_seq[k] = s;
          pending_words.push_back(upd(flow_ids[k], s));
        end
        default: begin
          s = flow_seq[k] + 16'd1;
          flow_seq[k] = s;
          pending_words.push_back(upd(flow_ids[k], s));
        end
      endcase
    end
  endtask

  initial begin
    min_received = 16'd10;
    max_seq = 16'd3;
    min_last = 16'd100;
    for (int i = 0; i < TableEntries; i++) begin
      used[i] = 1'b0; src_tab[i] = '0; first_tab[i] = '0; last_tab[i] = '0;
      rcv_tab[i] = '0; gap_tab[i] = '0; dup_tab[i] = '0;
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty report, extremes, wrap, jumps, dups, restart
    pending_words.push_back(rpt(5'd0));
    pending_words.push_back(rpt(5'd31));
    pending_words.push_back(upd(16'hFFFF, 16'hFFFF));
    pending_words.push_back(upd(16'hFFFF, 16'h0000));
    pending_words.push_back(upd(16'h0000, 16'h0000));
    pending_words.push_back(upd(16'h0000, 16'hFFFF));
    pending_words.push_back(upd(16'h0000, 16'h0005));
    pending_words.push_back(upd(16'h0000, 16'h0005));
    pending_words.push_back(upd(16'hA55A, 16'd200));
    for (int i = 1; i <= 12; i++) pending_words.push_back(upd(16'hA55A, 16'(200 + i)));
    pending_words.push_back(upd(16'hA55A, 16'd1));
    pending_words.push_back(rpt(5'd0));
    pending_words.push_back(rpt(5'd3));
    drain();

    // fill the table to get drops
    for (int i = 0; i < 34; i++) pending_words.push_back(upd(16'(16'h1000 + i), 16'(i)));
    for (int i = 0; i < 32; i++) pending_words.push_back(rpt(5'(i)));
    drain();

    write_reg(RegMinReceived, 16'd0);
    write_reg(RegMaxSeq, 16'hFFFF);
    write_reg(RegMinLast, 16'd0);
    random_phase(150, 6);
    drain();

    write_reg(RegMinReceived, 16'hFFFF);
    write_reg(RegMaxSeq, 16'd0);
    write_reg(RegMinLast, 16'hFFFF);
    random_phase(150, 6);
    drain();

    write_reg(RegMinReceived, 16'd5);
    write_reg(RegMaxSeq, 16'd4);
    write_reg(RegMinLast, 16'd50);
    random_phase(460, 5);
    drain();

    $display("covered %0d words: %0d reports, %0d drops, %0d restarts", accepted,
             reports, drops, restarts);
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule
